[rtl/lsdo_pkg.sv]
// shared types, codes and LED decode functions for the LED selector display
// no dependencies
package lsdo_pkg;

  localparam int LED_COUNT    = 8;
  localparam int TICKS_W      = 21;
  localparam int CFG_W        = 20;
  localparam int PORT_W       = 16;
  localparam int SEL_W        = 8;
  localparam int REQ_W        = 9;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [CFG_W-1:0]   OVERRIDE_TICKS_RST = CFG_W'(80000 * 5);
  localparam logic [REQ_W-1:0]   LAST_REQ_RST       = '1;
  localparam logic [TICKS_W-1:0] TICKS_IDLE         = '1;
  localparam logic [SEL_W:0]     BIN8_LIMIT         = 9'd256;
  localparam logic [SEL_W-1:0]   BIN4_LIMIT         = 8'd16;

  localparam logic [PORT_W-1:0] PORT_A_LED0 = 16'h0008;

  // port B pin index of each LED, LED0 lives on port A
  localparam logic [3:0] PORT_B_PIN [LED_COUNT] = '{
    4'd0, 4'd15, 4'd11, 4'd7, 4'd4, 4'd12, 4'd10, 4'd6
  };

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_OVR   = 2'd1,
    OP_TICK  = 2'd2,
    OP_BLANK = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_SPLIT = 2'd0,
    MODE_BIN4  = 2'd1,
    MODE_BIN8  = 2'd2,
    MODE_DARK  = 2'd3
  } mode_t;

  typedef struct packed {
    logic              override_active;
    logic [PORT_W-1:0] port_b_bits;
    logic [PORT_W-1:0] port_a_bits;
    logic [7:0]        led_mask;
  } result_t;

  function automatic logic [7:0] pattern_for(input logic [7:0] value, input mode_t mode);
    logic [7:0] p;
    logic [6:0] hi;
    p  = '0;
    hi = 7'(value[7:2]) + 7'd4;
    case (mode)
      MODE_SPLIT: begin
        p[value[1:0]] = 1'b1;
        if (hi < 7'(LED_COUNT)) p[hi[2:0]] = 1'b1;
      end
      MODE_BIN4: begin
        if (value < BIN4_LIMIT) p = value;
      end
      MODE_BIN8: begin
        if ({1'b0, value} < BIN8_LIMIT) p = value;
      end
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic [PORT_W-1:0] port_b_of(input logic [7:0] m);
    logic [PORT_W-1:0] b;
    b = '0;
    for (int i = 1; i < LED_COUNT; i++) begin
      if (m[i]) b[PORT_B_PIN[i]] = 1'b1;
    end
    return b;
  endfunction

endpackage

[rtl/lsdo_core.sv]
// display state, override countdown and per-transaction result decode
// depends on lsdo_pkg
module lsdo_core import lsdo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             item_fire,
  input  opcode_t          opcode,
  input  logic [7:0]       selector,
  input  mode_t            mode,
  output result_t          result
);

  logic [CFG_W-1:0]   override_ticks_r;
  logic [7:0]         base_sel_r, base_sel_nxt;
  logic [REQ_W-1:0]   last_req_r, last_req_nxt;
  logic               showing_r, showing_nxt;
  logic               fresh_r, fresh_nxt;
  logic [TICKS_W-1:0] ticks_r, ticks_nxt, ticks_dec;
  logic [7:0]         lit_r, lit_nxt;

  assign ticks_dec = ticks_r - TICKS_W'(1);

  always_comb begin
    base_sel_nxt = base_sel_r;
    last_req_nxt = last_req_r;
    showing_nxt  = showing_r;
    fresh_nxt    = fresh_r;
    ticks_nxt    = ticks_r;
    lit_nxt      = lit_r;
    case (opcode)
      OP_SET: begin
        base_sel_nxt = selector;
        showing_nxt  = 1'b0;
        last_req_nxt = '0;
        fresh_nxt    = 1'b1;
        lit_nxt      = pattern_for(selector, MODE_SPLIT);
      end
      OP_OVR: begin
        if ({1'b0, selector} != last_req_r) begin
          last_req_nxt = {1'b0, selector};
          if (fresh_r) begin
            fresh_nxt = 1'b0;
          end else begin
            showing_nxt = 1'b1;
            ticks_nxt   = {1'b0, override_ticks_r};
            lit_nxt     = pattern_for(selector, mode);
          end
        end
      end
      OP_TICK: begin
        // top bit set means the countdown is idle
        if (!ticks_r[TICKS_W-1]) begin
          ticks_nxt = ticks_dec;
          if (ticks_dec[TICKS_W-1]) begin
            showing_nxt = 1'b0;
            lit_nxt     = pattern_for(base_sel_r, MODE_SPLIT);
          end
        end
      end
      default: lit_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      override_ticks_r <= OVERRIDE_TICKS_RST;
      base_sel_r       <= '0;
      last_req_r       <= LAST_REQ_RST;
      showing_r        <= 1'b0;
      fresh_r          <= 1'b0;
      ticks_r          <= TICKS_IDLE;
      lit_r            <= '0;
    end else begin
      if (cfg_we) override_ticks_r <= cfg_wdata;
      if (item_fire) begin
        base_sel_r <= base_sel_nxt;
        last_req_r <= last_req_nxt;
        showing_r  <= showing_nxt;
        fresh_r    <= fresh_nxt;
        ticks_r    <= ticks_nxt;
        lit_r      <= lit_nxt;
      end
    end
  end

  always_comb begin
    result.led_mask        = lit_nxt;
    result.port_a_bits     = lit_nxt[0] ? PORT_A_LED0 : '0;
    result.port_b_bits     = port_b_of(lit_nxt);
    result.override_active = showing_nxt;
  end

endmodule

[rtl/lsdo_out_buf.sv]
// result register with a skid stage so input ready is a register
// depends on lsdo_pkg
module lsdo_out_buf import lsdo_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  result_t in_res,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t out_res_r;
  result_t skid_res_r;
  logic    out_valid_r;
  logic    skid_valid_r;

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) out_res_r <= skid_res_r;
    end else if (in_fire) begin
      if (!out_valid_r || out_ready) out_res_r <= in_res;
      else                           skid_res_r <= in_res;
    end
  end

endmodule

[rtl/led_selector_display_override.sv]
// each result is registered in the output register, or the skid stage on a stall
// throughput: one transaction per cycle; the single-pass decode in lsdo_core
//   and lsdo_out_buf's skid keep back-to-back transactions flowing until it fills
// reset: synchronous active-low; override_ticks returns to 400000, LEDs dark,
//   countdown idle, no result pending
module led_selector_display_override import lsdo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration: override tick count
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] selector, [9:8] mode, rest zero
  input  logic [1:0]             in_tuser,   // [1:0] opcode
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] led_mask, [23:8] port_a_bits,
                                             // [39:24] port_b_bits
  output logic                   out_tuser   // [0] override_active
);

  logic    in_fire;
  result_t core_res;
  result_t buf_res;

  // a transaction is taken whenever in_tvalid is high and the skid stage is empty
  assign in_fire = in_tvalid && in_tready;

  lsdo_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_fire (in_fire),
    .opcode    (opcode_t'(in_tuser)),
    .selector  (in_tdata[7:0]),
    .mode      (mode_t'(in_tdata[9:8])),
    .result    (core_res)
  );

  lsdo_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_res    (core_res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (buf_res)
  );

  // pack the result fields, led mask in the low byte
  assign out_tdata = {buf_res.port_b_bits, buf_res.port_a_bits, buf_res.led_mask};
  assign out_tuser = buf_res.override_active;

endmodule
